/* sv/t8ce_pkg.sv */
package t8ce_pkg;

  // item kinds on the input side
  localparam logic [1:0] KIND_EXEC  = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_LDRET = 2'd3;

  // opcodes, bits 19..17 of the instruction
  localparam logic [2:0] OPC_ADD   = 3'd0;
  localparam logic [2:0] OPC_ADDI  = 3'd1;
  localparam logic [2:0] OPC_MUL   = 3'd2;
  localparam logic [2:0] OPC_INV   = 3'd3;
  localparam logic [2:0] OPC_BR    = 3'd4;
  localparam logic [2:0] OPC_LOAD  = 3'd5;
  localparam logic [2:0] OPC_STORE = 3'd6;
  localparam logic [2:0] OPC_HALT  = 3'd7;

  // branch subcodes in the d field
  localparam logic [2:0] BR_EQ = 3'd0;
  localparam logic [2:0] BR_NE = 3'd1;
  localparam logic [2:0] BR_LT = 3'd2;

  // instruction field positions
  localparam int OPC_LSB = 17;
  localparam int D_LSB   = 14;
  localparam int S_LSB   = 11;
  localparam int T_LSB   = 8;

  // set-register index that addresses the pc
  localparam logic [3:0] PC_INDEX = 4'd8;

  localparam logic [1:0] LAT_NONE  = 2'd0;
  localparam logic [1:0] LAT_ONE   = 2'd1;
  localparam logic [1:0] LAT_TWO   = 2'd2;

  // queue geometry, shared by the decode queue and the result queue
  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    CLS_ADD,
    CLS_ADDI,
    CLS_MUL,
    CLS_INV,
    CLS_BEQ,
    CLS_BNE,
    CLS_BLT,
    CLS_BNOP,
    CLS_LOAD,
    CLS_STORE,
    CLS_HALT,
    CLS_SETR,
    CLS_SETPC,
    CLS_NOP,
    CLS_CLEAR,
    CLS_LDRET
  } cls_t;

  // decoded item; imm also carries the byte of set and load-return items
  typedef struct packed {
    cls_t       cls;
    logic [2:0] d;
    logic [2:0] s;
    logic [2:0] t;
    logic [7:0] imm;
  } uop_t;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       mem_read;
    logic       mem_write;
    logic [7:0] mem_address;
    logic [7:0] store_data;
    logic       halted;
    logic [1:0] latency;
  } result_t;

endpackage

/* sv/tiny_8bit_cpu_executor.sv */
// channel  | handshake           | payload
// ---------+---------------------+------------------------------------------------
// items    | push / full         | kind, instruction, reg_index, value
// results  | pop / empty         | next_pc, mem_read, mem_write, mem_address,
//          |                     | store_data, halted, latency
//
// one item a cycle is taken while full is low and one result a cycle is given while
// results are popped; a transferred item is written into the decode queue, and the
// execute stage writes its result into the result queue, from where it reaches the ports;
// both queues are four deep, so full rises only when results are not popped
// rst (synchronous) empties both queues and zeroes registers, pc and flags
module tiny_8bit_cpu_executor (
  input  logic        clk,
  input  logic        rst,
  // item side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [19:0] instruction,
  input  logic [3:0]  reg_index,
  input  logic [7:0]  value,
  // result side
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  next_pc,
  output logic        mem_read,
  output logic        mem_write,
  output logic [7:0]  mem_address,
  output logic [7:0]  store_data,
  output logic        halted,
  output logic [1:0]  latency
);
  import t8ce_pkg::*;

  uop_t    dec_uop;   // classified item from the front end
  uop_t    q_uop;     // oldest waiting item at the head of the decode queue
  logic    q_empty;
  logic    q_pop;
  result_t res;

  // front end: classify the item, no state of its own
  t8ce_front u_front (
    .kind        (kind),
    .instruction (instruction),
    .reg_index   (reg_index),
    .value       (value),
    .uop         (dec_uop)
  );

  // decode queue: lets the front keep taking items while the back stalls
  t8ce_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .uop_in  (dec_uop),
    .full    (full),
    .pop     (q_pop),
    .empty   (q_empty),
    .uop_out (q_uop)
  );

  // back end: register file, pc, halt and load tracking, result queue
  t8ce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_uop     (q_uop),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign next_pc     = res.next_pc;
  assign mem_read    = res.mem_read;
  assign mem_write   = res.mem_write;
  assign mem_address = res.mem_address;
  assign store_data  = res.store_data;
  assign halted      = res.halted;
  assign latency     = res.latency;

endmodule

/* sv/t8ce_front.sv */
module t8ce_front (
  input  logic [1:0]        kind,
  input  logic [19:0]       instruction,
  input  logic [3:0]        reg_index,
  input  logic [7:0]        value,
  output t8ce_pkg::uop_t    uop
);
  import t8ce_pkg::*;

  logic [2:0] opc;

  assign opc = instruction[OPC_LSB +: 3];

  always_comb begin
    uop.cls = CLS_NOP;
    uop.d   = instruction[D_LSB +: 3];
    uop.s   = instruction[S_LSB +: 3];
    uop.t   = instruction[T_LSB +: 3];
    uop.imm = instruction[7:0];
    unique case (kind)
      KIND_EXEC: begin
        unique case (opc)
          OPC_ADD:   uop.cls = CLS_ADD;
          OPC_ADDI:  uop.cls = CLS_ADDI;
          OPC_MUL:   uop.cls = CLS_MUL;
          OPC_INV:   uop.cls = CLS_INV;
          OPC_BR: begin
            unique case (instruction[D_LSB +: 3])
              BR_EQ:   uop.cls = CLS_BEQ;
              BR_NE:   uop.cls = CLS_BNE;
              BR_LT:   uop.cls = CLS_BLT;
              default: uop.cls = CLS_BNOP;
            endcase
          end
          OPC_LOAD:  uop.cls = CLS_LOAD;
          OPC_STORE: uop.cls = CLS_STORE;
          OPC_HALT:  uop.cls = CLS_HALT;
          default:   uop.cls = CLS_HALT;
        endcase
      end
      KIND_SET: begin
        uop.imm = value;
        uop.d   = reg_index[2:0];
        priority if (reg_index < PC_INDEX) begin
          uop.cls = CLS_SETR;
        end else if (reg_index == PC_INDEX) begin
          uop.cls = CLS_SETPC;
        end else begin
          uop.cls = CLS_NOP;
        end
      end
      KIND_CLEAR: uop.cls = CLS_CLEAR;
      KIND_LDRET: begin
        uop.cls = CLS_LDRET;
        uop.imm = value;
      end
      default: uop.cls = CLS_NOP;
    endcase
  end

endmodule

/* sv/t8ce_queue.sv */
module t8ce_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  t8ce_pkg::uop_t    uop_in,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output t8ce_pkg::uop_t    uop_out
);
  import t8ce_pkg::*;

  uop_t              mem [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign uop_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= uop_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

/* sv/t8ce_back.sv */
module t8ce_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  t8ce_pkg::uop_t      q_uop,
  output logic                q_pop,
  input  logic                res_pop,
  output logic                res_empty,
  output t8ce_pkg::result_t   res
);
  import t8ce_pkg::*;

  // architectural state
  logic [7:0] rf [8];
  logic [7:0] pc;
  logic       halt;
  logic       ldp;
  logic [2:0] ld_dest;

  logic [7:0] pc_next;
  logic       halt_next;
  logic       ldp_next;
  logic [2:0] ld_dest_next;
  logic       rf_we;
  logic [2:0] rf_wa;
  logic [7:0] rf_wd;
  logic       rf_clr;

  logic [7:0] rs;
  logic [7:0] rt;
  logic [7:0] pc_inc;
  logic [7:0] prod;
  logic       run;
  logic       take;
  result_t    r;

  // result queue
  result_t           rq [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              rq_full;
  logic              do_pop;

  assign rq_full   = (count == QCNT_W'(QDEPTH));
  assign res_empty = (count == '0);
  assign do_pop    = res_pop && !res_empty;
  assign res       = rq[rd_ptr];
  assign take      = !q_empty && !rq_full;
  assign q_pop     = take;

  assign rs     = rf[q_uop.s];
  assign rt     = rf[q_uop.t];
  assign pc_inc = pc + 8'd1;
  assign prod   = {4'b0, rs[7:4]} * {4'b0, rs[3:0]};
  assign run    = !halt && !ldp;

  always_comb begin
    pc_next      = pc;
    halt_next    = halt;
    ldp_next     = ldp;
    ld_dest_next = ld_dest;
    rf_we        = 1'b0;
    rf_wa        = q_uop.d;
    rf_wd        = '0;
    rf_clr       = 1'b0;
    r            = '0;
    unique case (q_uop.cls)
      CLS_ADD, CLS_ADDI, CLS_MUL, CLS_INV: begin
        if (run) begin
          rf_we   = 1'b1;
          pc_next = pc_inc;
          r.latency = LAT_ONE;
          unique case (q_uop.cls)
            CLS_ADD:  rf_wd = rs + rt;
            CLS_ADDI: rf_wd = rs + q_uop.imm;
            CLS_MUL: begin
              rf_wd     = prod;
              r.latency = LAT_TWO;
            end
            default:  rf_wd = ~rs;
          endcase
        end
      end
      CLS_BEQ, CLS_BNE, CLS_BLT: begin
        if (run) begin
          logic br;
          br = 1'b0;
          unique case (q_uop.cls)
            CLS_BEQ: br = (rs == rt);
            CLS_BNE: br = (rs != rt);
            default: br = (rs < rt);
          endcase
          pc_next   = br ? q_uop.imm : pc_inc;
          r.latency = br ? LAT_TWO : LAT_ONE;
        end
      end
      CLS_LOAD: begin
        if (run) begin
          r.mem_read    = 1'b1;
          r.mem_address = rt;
          ldp_next      = 1'b1;
          ld_dest_next  = q_uop.d;
          pc_next       = pc_inc;
        end
      end
      CLS_STORE: begin
        if (run) begin
          r.mem_write   = 1'b1;
          r.mem_address = rt;
          r.store_data  = rs;
          pc_next       = pc_inc;
        end
      end
      CLS_HALT: begin
        if (run) begin
          halt_next = 1'b1;
          pc_next   = pc_inc;
        end
      end
      CLS_SETR: begin
        rf_we = 1'b1;
        rf_wd = q_uop.imm;
      end
      CLS_SETPC: begin
        pc_next   = q_uop.imm;
        halt_next = 1'b0;
        ldp_next  = 1'b0;
      end
      CLS_CLEAR: begin
        rf_clr    = 1'b1;
        pc_next   = '0;
        halt_next = 1'b0;
        ldp_next  = 1'b0;
      end
      CLS_LDRET: begin
        if (ldp) begin
          rf_we    = 1'b1;
          rf_wa    = ld_dest;
          rf_wd    = q_uop.imm;
          ldp_next = 1'b0;
        end
      end
      default: ;
    endcase
    r.next_pc = pc_next;
    r.halted  = halt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) rf[i] <= '0;
      pc      <= '0;
      halt    <= 1'b0;
      ldp     <= 1'b0;
      ld_dest <= '0;
    end else if (take) begin
      pc      <= pc_next;
      halt    <= halt_next;
      ldp     <= ldp_next;
      ld_dest <= ld_dest_next;
      if (rf_clr) begin
        for (int i = 0; i < 8; i++) rf[i] <= '0;
      end else if (rf_we) begin
        rf[rf_wa] <= rf_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rq[wr_ptr] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(take) - QCNT_W'(do_pop);
    end
  end

endmodule

/* sv/t8ce_checker.sv */
module t8ce_checker (
  input logic       clk,
  input logic       rst,
  input logic       pop,
  input logic       empty,
  input logic       mem_read,
  input logic       mem_write,
  input logic [7:0] mem_address,
  input logic [7:0] store_data,
  input logic [1:0] latency
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // one memory request at most per result
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(mem_read && mem_write))
    else $error("load and store in one result");

  // memory ops report no latency
  a_mem_lat: assert property (@(posedge clk) disable iff (rst)
    (!empty && (mem_read || mem_write)) |-> latency == 2'd0)
    else $error("memory request with nonzero latency");

  // unused request fields read as zero
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && !mem_write) |-> (store_data == 8'd0 &&
      (mem_read || mem_address == 8'd0)))
    else $error("request fields set without a request");

  // a waiting result stays until it is popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without a pop");

endmodule

bind tiny_8bit_cpu_executor t8ce_checker u_t8ce_checker (
  .clk         (clk),
  .rst         (rst),
  .pop         (pop),
  .empty       (empty),
  .mem_read    (mem_read),
  .mem_write   (mem_write),
  .mem_address (mem_address),
  .store_data  (store_data),
  .latency     (latency)
);

/* test/tb.sv */
`timescale 1ns / 100ps

// tiny cpu executor: directed checks of every operation and corner case, then
// a long random run steered by the predicted machine state, with random gaps
// on the item side and random stalls on the result side
module tb;
  import t8ce_pkg::*;

  localparam int IDLE_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 8;   // settle time after the last result

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  kind;
  logic [19:0] instruction;
  logic [3:0]  reg_index;
  logic [7:0]  value;
  logic        pop;
  logic        empty;
  logic [7:0]  next_pc;
  logic        mem_read;
  logic        mem_write;
  logic [7:0]  mem_address;
  logic [7:0]  store_data;
  logic        halted;
  logic [1:0]  latency;

  // predicted machine state
  logic [7:0] cpu_regs [8];
  logic [7:0] cpu_pc;
  bit         cpu_halted;
  bit         load_waiting;
  logic [2:0] load_reg;
  bit         item_ignored;  // last predicted item left the machine as it was

  result_t results_due [$];
  int      error_count;
  int      idle_cycles;
  bit      steady;  // no gaps and no stalls while set

  tiny_8bit_cpu_executor i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .instruction (instruction),
    .reg_index   (reg_index),
    .value       (value),
    .pop         (pop),
    .empty       (empty),
    .next_pc     (next_pc),
    .mem_read    (mem_read),
    .mem_write   (mem_write),
    .mem_address (mem_address),
    .store_data  (store_data),
    .halted      (halted),
    .latency     (latency)
  );

  always #5 clk = ~clk;

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [19:0] mk_ins(input logic [2:0] opc, input logic [2:0] d,
                                         input logic [2:0] s, input logic [2:0] t,
                                         input logic [7:0] imm);
    return {opc, d, s, t, imm};
  endfunction

  // predict one item and queue the result it must produce
  task automatic cpu_step(input logic [1:0] k, input logic [19:0] ins,
                          input logic [3:0] ri, input logic [7:0] v);
    result_t    res;
    logic [2:0] opc, d, s, t;
    logic [7:0] imm, rs, rt, seq_pc;
    bit         take;
    res = '0;
    item_ignored = 1'b0;
    case (k)
      KIND_EXEC: begin
        if (cpu_halted || load_waiting) begin
          // the machine is stopped or waiting on load data
          item_ignored = 1'b1;
        end else begin
          opc    = ins[OPC_LSB +: 3];
          d      = ins[D_LSB +: 3];
          s      = ins[S_LSB +: 3];
          t      = ins[T_LSB +: 3];
          imm    = ins[7:0];
          rs     = cpu_regs[s];
          rt     = cpu_regs[t];
          seq_pc = cpu_pc + 8'd1;
          case (opc)
            OPC_ADD: begin
              cpu_regs[d] = rs + rt;
              cpu_pc = seq_pc;
              res.latency = LAT_ONE;
            end
            OPC_ADDI: begin
              cpu_regs[d] = rs + imm;
              cpu_pc = seq_pc;
              res.latency = LAT_ONE;
            end
            OPC_MUL: begin
              cpu_regs[d] = {4'd0, rs[7:4]} * {4'd0, rs[3:0]};
              cpu_pc = seq_pc;
              res.latency = LAT_TWO;
            end
            OPC_INV: begin
              cpu_regs[d] = ~rs;
              cpu_pc = seq_pc;
              res.latency = LAT_ONE;
            end
            OPC_BR: begin
              if (d == BR_EQ || d == BR_NE || d == BR_LT) begin
                if (d == BR_EQ) take = (rs == rt);
                else if (d == BR_NE) take = (rs != rt);
                else take = (rs < rt);
                if (take) begin
                  cpu_pc = imm;
                  res.latency = LAT_TWO;
                end else begin
                  cpu_pc = seq_pc;
                  res.latency = LAT_ONE;
                end
              end else begin
                // undefined subcode: nothing moves
                item_ignored = 1'b1;
              end
            end
            OPC_LOAD: begin
              res.mem_read = 1'b1;
              res.mem_address = rt;
              load_waiting = 1'b1;
              load_reg = d;
              cpu_pc = seq_pc;
            end
            OPC_STORE: begin
              res.mem_write = 1'b1;
              res.mem_address = rt;
              res.store_data = rs;
              cpu_pc = seq_pc;
            end
            default: begin
              cpu_halted = 1'b1;
              cpu_pc = seq_pc;
            end
          endcase
        end
      end
      KIND_SET: begin
        if (ri < PC_INDEX) begin
          cpu_regs[ri[2:0]] = v;
        end else if (ri == PC_INDEX) begin
          // writing the pc also restarts the machine
          cpu_pc = v;
          cpu_halted = 1'b0;
          load_waiting = 1'b0;
        end else begin
          item_ignored = 1'b1;
        end
      end
      KIND_CLEAR: begin
        foreach (cpu_regs[i]) cpu_regs[i] = 8'd0;
        cpu_pc = 8'd0;
        cpu_halted = 1'b0;
        load_waiting = 1'b0;
      end
      default: begin
        if (load_waiting) begin
          cpu_regs[load_reg] = v;
          load_waiting = 1'b0;
        end else begin
          item_ignored = 1'b1;
        end
      end
    endcase
    res.next_pc = cpu_pc;
    res.halted = cpu_halted;
    results_due.push_back(res);
  endtask

  // one item transfer; entered and left at a falling edge, push stays high
  // between back-to-back items
  task automatic send_item(input logic [1:0] k, input logic [19:0] ins,
                           input logic [3:0] ri, input logic [7:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    kind        <= k;
    instruction <= ins;
    reg_index   <= ri;
    value       <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    cpu_step(k, ins, ri, v);
    @(negedge clk);
  endtask

  task automatic send_exec(input logic [19:0] ins);
    send_item(KIND_EXEC, ins, 4'($urandom), 8'($urandom));
  endtask

  task automatic send_set(input logic [3:0] ri, input logic [7:0] v);
    send_item(KIND_SET, 20'($urandom), ri, v);
  endtask

  task automatic send_load_data(input logic [7:0] v);
    send_item(KIND_LDRET, 20'($urandom), 4'($urandom), v);
  endtask

  // arithmetic extremes: add wrap, addi wrap, largest nibble product, invert
  task automatic test_alu();
    send_set(4'd1, 8'hFF);
    send_set(4'd2, 8'h01);
    send_exec(mk_ins(OPC_ADD, 3'd3, 3'd1, 3'd2, 8'h00));
    send_exec(mk_ins(OPC_ADDI, 3'd4, 3'd1, 3'd0, 8'hFF));
    send_exec(mk_ins(OPC_MUL, 3'd5, 3'd1, 3'd0, 8'h00));
    send_exec(mk_ins(OPC_INV, 3'd6, 3'd2, 3'd0, 8'h00));
  endtask

  // taken and untaken branches, pc wrap, undefined subcode
  task automatic test_branches();
    send_exec(mk_ins(OPC_BR, BR_EQ, 3'd0, 3'd0, 8'hFF));
    send_exec(mk_ins(OPC_ADD, 3'd0, 3'd0, 3'd0, 8'h00));  // pc wraps to zero
    send_exec(mk_ins(OPC_BR, BR_NE, 3'd1, 3'd2, 8'h10));
    send_exec(mk_ins(OPC_BR, BR_LT, 3'd2, 3'd1, 8'h20));
    send_exec(mk_ins(OPC_BR, BR_LT, 3'd1, 3'd2, 8'h30));
    send_exec(mk_ins(OPC_BR, 3'd7, 3'd0, 3'd0, 8'h40));
  endtask

  // load hold-off, load data return, stray return, store
  task automatic test_memory();
    send_exec(mk_ins(OPC_LOAD, 3'd7, 3'd0, 3'd2, 8'h00));
    send_exec(mk_ins(OPC_ADD, 3'd0, 3'd1, 3'd1, 8'h00));  // ignored while the load is pending
    send_load_data(8'hA5);
    send_load_data(8'h5A);                                // nothing pending
    send_exec(mk_ins(OPC_STORE, 3'd0, 3'd7, 3'd1, 8'h00));
  endtask

  // halt, restart through the pc, bad register index, clear
  task automatic test_control();
    send_exec(mk_ins(OPC_HALT, 3'd0, 3'd0, 3'd0, 8'h00));
    send_exec(mk_ins(OPC_ADDI, 3'd0, 3'd0, 3'd0, 8'h01));  // ignored while halted
    send_set(4'd15, 8'hAA);
    send_set(PC_INDEX, 8'h80);
    send_exec(mk_ins(OPC_LOAD, 3'd3, 3'd0, 3'd0, 8'h00));
    send_set(PC_INDEX, 8'h00);  // drops the pending load
    send_item(KIND_CLEAR, 20'hFFFFF, 4'hF, 8'hFF);
  endtask

  // random execute word; branches lean on defined subcodes and equal operands
  function automatic logic [19:0] rand_instruction();
    logic [2:0] opc, d, s, t;
    opc = 3'($urandom);
    if (opc == OPC_HALT && $urandom_range(0, 1)) opc = 3'($urandom_range(0, 6));
    d = 3'($urandom);
    s = 3'($urandom);
    t = 3'($urandom);
    if (opc == OPC_BR) begin
      if ($urandom_range(0, 3) != 0) d = 3'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) t = s;
    end
    return mk_ins(opc, d, s, t, 8'($urandom));
  endfunction

  // random run; mostly sensible programs, recovery from halt and loads,
  // plus fully random noise
  task automatic test_random(input int n_items);
    int done, roll;
    logic [7:0] v;
    done = 0;
    while (done < n_items) begin
      if (done % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      v = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      if (cpu_halted && roll < 70) begin
        if (roll < 55) send_set(PC_INDEX, 8'($urandom));
        else send_item(KIND_CLEAR, 20'($urandom), 4'($urandom), 8'($urandom));
      end else if (load_waiting && roll < 70) begin
        send_load_data(8'($urandom));
      end else if (roll < 65) begin
        send_exec(rand_instruction());
      end else if (roll < 85) begin
        send_set($urandom_range(0, 3) != 0 ? 4'($urandom_range(0, 8)) : 4'($urandom), v);
      end else if (roll < 88) begin
        send_item(KIND_CLEAR, 20'($urandom), 4'($urandom), 8'($urandom));
      end else if (roll < 93) begin
        send_load_data(8'($urandom));
      end else begin
        send_item(2'($urandom), 20'($urandom), 4'($urandom), 8'($urandom));
      end
      if (!item_ignored) done++;
    end
    steady = 1'b0;
  endtask

  // result side: pop runs of random length broken by random stalls
  initial begin
    int stall;
    pop = 1'b0;
    @(negedge clk);
    forever begin
      pop <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual pc %0h",
                 $time, next_pc);
        error_count++;
      end else begin
        want = results_due.pop_front();
        check_field("next_pc", want.next_pc, next_pc);
        check_field("mem_read", want.mem_read, mem_read);
        check_field("mem_write", want.mem_write, mem_write);
        check_field("mem_address", want.mem_address, mem_address);
        check_field("store_data", want.store_data, store_data);
        check_field("halted", want.halted, halted);
        check_field("latency", want.latency, latency);
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    kind = KIND_EXEC;
    instruction = 20'd0;
    reg_index = 4'd0;
    value = 8'd0;
    error_count = 0;
    idle_cycles = 0;
    steady = 1'b0;
    foreach (cpu_regs[i]) cpu_regs[i] = 8'd0;
    cpu_pc = 8'd0;
    cpu_halted = 1'b0;
    load_waiting = 1'b0;
    load_reg = 3'd0;
    item_ignored = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_alu();
    test_branches();
    test_memory();
    test_control();
    test_random(800);

    push <= 1'b0;
    // drain the results still in flight, then make sure nothing extra follows
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/t8ce_pkg.sv
sv/t8ce_front.sv
sv/t8ce_queue.sv
sv/t8ce_back.sv
sv/tiny_8bit_cpu_executor.sv
sv/t8ce_checker.sv
test/tb.sv
